FILE: design/spc_pkg.sv
// shared types and constants of the stepped phase counter
`default_nettype none

package spc_pkg;

  // fixed field widths
  localparam int STEP_CNT_W = 13;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int OUT_USER_W = 2;

  // request kinds carried on in_tuser
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RESET = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_RANGE = 2'd2;

  localparam logic [STEP_CNT_W-1:0] STEP_COUNT_RST = 13'd128;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_HOLD
  } spc_state_t;

endpackage

`default_nettype wire

FILE: design/spc_addsub.sv
// shared add/subtract unit used by the divide and multiply sequences
`default_nettype none

module spc_addsub #(
  parameter int W = 14
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W-1:0] res,
  output logic              carry
);

  logic [W:0] sum;

  // a + b, or a - b as a + ~b + 1; carry high on subtract means no borrow
  assign sum   = {1'b0, a} + {1'b0, (b ^ {W{sub}})} + {{W{1'b0}}, sub};
  assign res   = sum[W-1:0];
  assign carry = sum[W];

endmodule

`default_nettype wire

FILE: design/stepped_phase_counter_core.sv
// stepped phase counter: modulo step index with fractional phase readout
//
//  channel | direction | tdata / data                | tuser / index
//  --------+-----------+-----------------------------+-----------------------------
//  in_     | slave     | phase_frac                  | req_type
//  out_    | master    | phase_value                 | cycle_end, phase_error
//  cfg_    | slave     | register value              | register index
//
// a tick whose index lies below n runs a restoring divide (one bit of the
// restoring divide per cycle through the shared adder); a set phase with a
// fraction below 1.0 runs a shift-add multiply; other requests go straight
// to the hold state. in_tready is high only while the sequencer is idle.
// a finished result waits in the hold state while the output register is full.
// reset (rst_n low, synchronous) restores the register defaults and index 0.
`default_nettype none

module stepped_phase_counter_core #(
  parameter int MAX_STEPS = 4096,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  // input items
  input  wire logic                                          in_tvalid,
  output logic                                               in_tready,
  input  wire logic [((FRAC_BITS+8)/8)*8-1:0]                in_tdata,  // phase_frac
  input  wire logic [spc_pkg::REQ_W-1:0]                     in_tuser,  // req_type
  // result items
  output logic                                               out_tvalid,
  input  wire logic                                          out_tready,
  output logic      [((FRAC_BITS+8)/8)*8-1:0]                out_tdata, // phase_value
  output logic      [spc_pkg::OUT_USER_W-1:0]                out_tuser, // cycle_end, phase_error
  // configuration writes
  input  wire logic                                          cfg_valid,
  output logic                                               cfg_ready,
  input  wire logic [spc_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  wire logic [spc_pkg::CFG_DATA_W-1:0]                cfg_data
);

  import spc_pkg::*;

  localparam int IW  = $clog2(MAX_STEPS);
  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int FW  = FRAC_BITS + 1;
  localparam int DW  = ((FRAC_BITS + 8) / 8) * 8;
  localparam int CNW = $clog2(FRAC_BITS + 1);
  localparam int UW  = SW + 1;

  localparam logic [FW-1:0]  ONE_Q    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CNW-1:0] LAST_CNT = CNW'(FRAC_BITS - 1);

  // registers
  spc_state_t               state_r, state_nxt;
  logic [STEP_CNT_W-1:0]    step_count_r;
  logic                     count_down_r;
  logic                     open_range_r;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [SW-1:0]            rem_r, rem_nxt;         // divide remainder / multiply sum
  logic [FRAC_BITS-1:0]     sh_r, sh_nxt;           // quotient bits / multiplier bits
  logic [CNW-1:0]           cnt_r, cnt_nxt;
  logic [FW-1:0]            res_value_r, res_value_nxt;
  logic                     res_end_r, res_end_nxt;
  logic                     res_err_r, res_err_nxt;
  logic                     out_tvalid_r;
  logic [FW-1:0]            out_value_r;
  logic                     out_end_r;
  logic                     out_err_r;

  logic                     in_acc;
  logic                     out_free;
  logic [SW-1:0]            eff_s;
  logic [SW-1:0]            n_div;
  logic [FW-1:0]            frac;
  logic [UW-1:0]            u_a, u_b, u_res;
  logic                     u_sub, u_carry;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign frac     = in_tdata[FW-1:0];

  // effective step count, saturated to [3, MAX_STEPS], and the divisor n
  always_comb begin
    if (step_count_r < STEP_CNT_W'(3)) begin
      eff_s = SW'(3);
    end else if (32'(step_count_r) > MAX_STEPS) begin
      eff_s = SW'(MAX_STEPS);
    end else begin
      eff_s = SW'(step_count_r);
    end
    n_div = open_range_r ? eff_s : eff_s - SW'(1);
  end

  // shared unit operands
  always_comb begin
    if (state_r == ST_DIV) begin
      u_a   = {rem_r, 1'b0};
      u_b   = {1'b0, n_div};
      u_sub = 1'b1;
    end else begin
      u_a   = {1'b0, rem_r};
      u_b   = sh_r[0] ? {1'b0, n_div} : '0;
      u_sub = 1'b0;
    end
  end

  spc_addsub #(.W(UW)) u_addsub (
    .a     (u_a),
    .b     (u_b),
    .sub   (u_sub),
    .res   (u_res),
    .carry (u_carry)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == REQ_TICK && 32'(idx_r) < 32'(n_div)) begin
            state_nxt = ST_DIV;
          end else if (in_tuser == REQ_SET && frac < ONE_Q) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_DIV, ST_MUL: begin
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    res_value_nxt = res_value_r;
    res_end_nxt   = res_end_r;
    res_err_nxt   = res_err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_value_nxt = '0;
          res_end_nxt   = 1'b0;
          res_err_nxt   = 1'b0;
          cnt_nxt       = '0;
          rem_nxt       = '0;
          sh_nxt        = '0;
          case (in_tuser)
            REQ_TICK: begin
              // readout of the current index, clamped at 1.0 when idx >= n
              rem_nxt = SW'(idx_r);
              if (32'(idx_r) >= 32'(n_div)) begin
                res_value_nxt = ONE_Q;
              end
              // advance the index with wrap
              if (count_down_r) begin
                if (idx_r == '0) begin
                  idx_nxt     = IW'(eff_s - SW'(1));
                  res_end_nxt = 1'b1;
                end else begin
                  idx_nxt = idx_r - IW'(1);
                end
              end else begin
                if (32'(idx_r) + 1 < 32'(eff_s)) begin
                  idx_nxt = idx_r + IW'(1);
                end else begin
                  idx_nxt     = '0;
                  res_end_nxt = 1'b1;
                end
              end
            end
            REQ_RESET: begin
              idx_nxt = count_down_r ? IW'(eff_s - SW'(1)) : '0;
            end
            REQ_SET: begin
              if (frac > ONE_Q) begin
                res_err_nxt = 1'b1;
              end else if (frac == ONE_Q) begin
                idx_nxt = open_range_r ? '0 : IW'(n_div);
              end else begin
                sh_nxt = frac[FRAC_BITS-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, remainder stays below n
        if (u_carry) begin
          rem_nxt = u_res[SW-1:0];
        end else begin
          rem_nxt = u_a[SW-1:0];
        end
        sh_nxt  = {sh_r[FRAC_BITS-2:0], u_carry};
        cnt_nxt = cnt_r + CNW'(1);
        if (cnt_r == LAST_CNT) begin
          res_value_nxt = {1'b0, sh_r[FRAC_BITS-2:0], u_carry};
        end
      end
      ST_MUL: begin
        // lsb-first shift-add, sum shifted right each step
        rem_nxt = u_res[SW:1];
        sh_nxt  = {1'b0, sh_r[FRAC_BITS-1:1]};
        cnt_nxt = cnt_r + CNW'(1);
        if (cnt_r == LAST_CNT) begin
          idx_nxt = IW'(u_res[SW:1]);
        end
      end
      ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_count_r <= STEP_COUNT_RST;
      count_down_r <= 1'b0;
      open_range_r <= 1'b0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEP_COUNT: step_count_r <= cfg_data[STEP_CNT_W-1:0];
          REG_COUNT_DOWN: count_down_r <= cfg_data[0];
          REG_OPEN_RANGE: open_range_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      // output register
      if (state_r == ST_HOLD && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    sh_r        <= sh_nxt;
    cnt_r       <= cnt_nxt;
    res_value_r <= res_value_nxt;
    res_end_r   <= res_end_nxt;
    res_err_r   <= res_err_nxt;
    if (state_r == ST_HOLD && out_free) begin
      out_value_r <= res_value_r;
      out_end_r   <= res_end_r;
      out_err_r   <= res_err_r;
    end
  end

  // ports
  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DW'(out_value_r);
  assign out_tuser  = {out_err_r, out_end_r};

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for the stepped phase counter core
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spc_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int ONE_Q        = 1 << FRAC_BITS;
  localparam int MAX_STEPS    = 4096;
  localparam int RANDOM_ITEMS = 1850;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_WAIT  = 40;

  // codes the package leaves unnamed
  localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [FRAC_BITS:0] value;
    logic               cycle_end;
    logic               phase_error;
  } phase_result_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         code;   // request kind or register index
    logic [FRAC_BITS:0] arg;    // phase fraction or register value
    logic               typed;  // expectation given in the row
    phase_result_t      res;
  } stim_row_t;

  localparam phase_result_t R_ZERO = '{17'd0, 1'b0, 1'b0};
  localparam phase_result_t R_ERR  = '{17'd0, 1'b0, 1'b1};
  localparam phase_result_t R_ONE  = '{17'd65536, 1'b0, 1'b0};
  localparam phase_result_t R_ONEW = '{17'd65536, 1'b1, 1'b0};
  localparam phase_result_t R_WRAP = '{17'd0, 1'b1, 1'b0};

  localparam int DIR_ROWS = 29;

  // directed walk: reset values, range ends, saturation, error and unused codes
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b1, R_ZERO},  // first tick after reset
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b0, R_ZERO},
    '{ROW_ITEM, REQ_SET,        17'd65536,  1'b1, R_ZERO},  // 1.0 closed -> last step
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b1, R_ONEW},  // full scale, wraps
    '{ROW_ITEM, REQ_SET,        17'd131071, 1'b1, R_ERR},   // above 1.0
    '{ROW_ITEM, REQ_SET,        17'd65537,  1'b1, R_ERR},
    '{ROW_ITEM, REQ_UNUSED,     17'd131071, 1'b1, R_ZERO},
    '{ROW_ITEM, REQ_RESET,      17'd0,      1'b1, R_ZERO},
    '{ROW_ITEM, REQ_SET,        17'd32768,  1'b1, R_ZERO},
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b0, R_ZERO},
    '{ROW_CFG,  REG_COUNT_DOWN, 17'd1,      1'b0, R_ZERO},
    '{ROW_ITEM, REQ_RESET,      17'd0,      1'b1, R_ZERO},  // down: index at last step
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b1, R_ONE},
    '{ROW_ITEM, REQ_SET,        17'd0,      1'b1, R_ZERO},
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b1, R_WRAP},  // down from zero wraps
    '{ROW_CFG,  REG_OPEN_RANGE, 17'd1,      1'b0, R_ZERO},
    '{ROW_ITEM, REQ_SET,        17'd65536,  1'b1, R_ZERO},  // 1.0 open -> index 0
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b1, R_WRAP},
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b0, R_ZERO},
    '{ROW_CFG,  REG_STEP_COUNT, 17'd0,      1'b0, R_ZERO},  // saturates to 3
    '{ROW_CFG,  REG_COUNT_DOWN, 17'd0,      1'b0, R_ZERO},
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b1, R_ONEW},  // index past step count
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b1, R_ZERO},
    '{ROW_CFG,  REG_STEP_COUNT, 17'd8191,   1'b0, R_ZERO},  // saturates to max
    '{ROW_CFG,  REG_OPEN_RANGE, 17'd0,      1'b0, R_ZERO},
    '{ROW_ITEM, REQ_SET,        17'd65535,  1'b0, R_ZERO},
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b0, R_ZERO},
    '{ROW_CFG,  REG_UNUSED,     17'd8191,   1'b0, R_ZERO},
    '{ROW_ITEM, REQ_TICK,       17'd0,      1'b0, R_ZERO}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [23:0]            in_tdata = '0;   // phase_frac
  logic [REQ_W-1:0]       in_tuser = '0;   // req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [23:0]            out_tdata;       // phase_value
  logic [OUT_USER_W-1:0]  out_tuser;       // cycle_end, phase_error
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // shadow state of the counter
  logic [STEP_CNT_W-1:0]  shadow_steps = STEP_COUNT_RST;
  logic                   shadow_down = 1'b0;
  logic                   shadow_open = 1'b0;
  logic [11:0]            shadow_index = '0;

  phase_result_t pending_phases [$];
  int            fail_count = 0;
  int            stall_cycles = 0;
  bit            calm = 1'b0;
  int unsigned   ready_hold = 0;

  stepped_phase_counter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  // mostly short gaps, now and then a long one, none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // expected result of one request, advancing the shadow index
  function automatic phase_result_t phase_advance(logic [1:0] req, logic [FRAC_BITS:0] frac);
    phase_result_t     res;
    int unsigned       steps;
    int unsigned       n;
    longint unsigned   q;
    longint unsigned   f;
    res = '0;
    steps = shadow_steps;
    if (steps < 3) steps = 3;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    n = shadow_open ? steps : steps - 1;
    case (req)
      REQ_TICK: begin
        q = (longint'(shadow_index) << FRAC_BITS) / n;
        if (q > ONE_Q) q = ONE_Q;
        res.value = q[FRAC_BITS:0];
        if (shadow_down) begin
          if (shadow_index == 0) begin
            shadow_index = 12'(steps - 1);
            res.cycle_end = 1'b1;
          end else begin
            shadow_index = shadow_index - 12'd1;
          end
        end else if (int'(shadow_index) + 1 < steps) begin
          shadow_index = shadow_index + 12'd1;
        end else begin
          shadow_index = '0;
          res.cycle_end = 1'b1;
        end
      end
      REQ_RESET: begin
        shadow_index = shadow_down ? 12'(steps - 1) : 12'd0;
      end
      REQ_SET: begin
        if (frac > ONE_Q) begin
          res.phase_error = 1'b1;
        end else begin
          f = (shadow_open && frac == ONE_Q) ? 0 : frac;
          shadow_index = 12'((longint'(n) * f) >> FRAC_BITS);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // offer one request; the expectation is the row's own or the shadow's
  task automatic send_request(input logic [1:0] req, input logic [FRAC_BITS:0] frac,
                              input logic typed, input phase_result_t given);
    int unsigned   gap;
    phase_result_t want;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, frac};
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    want = phase_advance(req, frac);
    pending_phases.push_back(typed ? given : want);
  endtask

  // hold the input back until every result is out
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_all_results();
    // let the sequencer settle back to idle
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEP_COUNT: shadow_steps = data;
      REG_COUNT_DOWN: shadow_down = data[0];
      REG_OPEN_RANGE: shadow_open = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_step_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return CFG_DATA_W'($urandom_range(0, 3));
    if (r < 15) return CFG_DATA_W'(MAX_STEPS);
    if (r < 20) return CFG_DATA_W'($urandom_range(MAX_STEPS + 1, 8191));
    if (r < 25) return 13'd8191;
    if (r < 75) return CFG_DATA_W'($urandom_range(3, 20));
    return CFG_DATA_W'($urandom_range(21, MAX_STEPS - 1));
  endfunction

  function automatic logic [FRAC_BITS:0] pick_fraction();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return (FRAC_BITS+1)'(ONE_Q);
    if (r < 30) return (FRAC_BITS+1)'($urandom_range(ONE_Q + 1, 131071));
    if (r < 35) return 17'd131071;
    return (FRAC_BITS+1)'($urandom_range(0, ONE_Q - 1));
  endfunction

  // main sequence
  initial begin
    int            random_items;
    int unsigned   phase_len;
    int unsigned   r;
    logic [1:0]    req;
    random_items = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG)
        write_register(DIR_TABLE[i].code, DIR_TABLE[i].arg[CFG_DATA_W-1:0]);
      else
        send_request(DIR_TABLE[i].code, DIR_TABLE[i].arg, DIR_TABLE[i].typed,
                     DIR_TABLE[i].res);
    end

    // random phases, each under a fresh register setting
    while (random_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      write_register(REG_STEP_COUNT, pick_step_count());
      write_register(REG_COUNT_DOWN, {12'($urandom), 1'($urandom_range(0, 1))});
      write_register(REG_OPEN_RANGE, {12'($urandom), 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 9) == 0)
        write_register(REG_UNUSED, 13'($urandom));
      phase_len = $urandom_range(30, 120);
      for (int k = 0; k < phase_len && random_items < RANDOM_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 65)      req = REQ_TICK;
        else if (r < 72) req = REQ_RESET;
        else if (r < 95) req = REQ_SET;
        else             req = REQ_UNUSED;
        // occasional full drain mid-phase
        if ($urandom_range(0, 149) == 0) wait_all_results();
        send_request(req, pick_fraction(), 1'b0, R_ZERO);
        random_items++;
      end
    end

    wait_all_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin : drive_ready
    int unsigned gap;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_tready) begin
      gap = pick_gap();
      if (gap != 0) begin
        out_tready <= 1'b0;
        ready_hold <= gap - 1;
      end else begin
        ready_hold <= $urandom_range(0, 15);
      end
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 20);
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    phase_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_phases.size() == 0) begin
        $display("%0t: unexpected result item: value %0d cycle_end %b phase_error %b",
                 $time, out_tdata[FRAC_BITS:0], out_tuser[0], out_tuser[1]);
        fail_count++;
      end else begin
        want = pending_phases.pop_front();
        if (out_tdata[FRAC_BITS:0] !== want.value) begin
          $display("%0t: phase_value expected %0d actual %0d",
                   $time, want.value, out_tdata[FRAC_BITS:0]);
          fail_count++;
        end
        if (out_tuser[0] !== want.cycle_end) begin
          $display("%0t: cycle_end expected %b actual %b", $time, want.cycle_end, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] !== want.phase_error) begin
          $display("%0t: phase_error expected %b actual %b",
                   $time, want.phase_error, out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  // end the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

`default_nettype wire
